// ----- hdl/stc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types and constants of the sensor trim compensation block.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] REG_TEMP     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESS_LO = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESS_HI = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_P9_HUM   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HUM_HI   = 3'd4;

  localparam logic [19:0] SKIP20  = 20'h80000;
  localparam logic [15:0] SKIP16  = 16'h8000;
  localparam logic [31:0] HUM_CAP = 32'd419430400;

  // Operand selects for the shared multiplier.
  typedef enum logic [4:0] {
    OP_T_A,   OP_T_B,   OP_T_C,   OP_T_D,   OP_T_E,
    OP_P_A,   OP_P_B,   OP_P_C,   OP_P_D,   OP_P_E,
    OP_P_F,   OP_P_G,   OP_P_H,   OP_P_I,   OP_P_J,
    OP_P_K,   OP_P_L,   OP_P_M,   OP_H_A,   OP_H_B,
    OP_H_C,   OP_H_D,   OP_H_E,   OP_H_F,   OP_H_G,
    OP_H_H,   OP_H_I,   OP_NONE
  } op_t;

  typedef struct packed {
    logic load;     // capture input item
    logic step;     // execute op in this cycle
    op_t  op;
    logic div_start;
    logic publish;  // move results to the output register
  } dp_cmd_t;

  typedef struct packed {
    logic tv;
    logic pv;
    logic hv;
    logic div_busy;
    logic div_zero;
  } dp_sts_t;

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
    asr = 32'($signed(v) >>> n);
  endfunction

endpackage
`default_nettype wire

// ----- hdl/stc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_if
// Valid/ready channel carrying a payload of parameterized type width.
// ----------------------------------------------------------------------------
interface stc_if #(
  parameter int unsigned Width = 8
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/sensor_trim_compensation.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_trim_compensation
// Integer trim compensation of temperature, pressure and humidity readings.
// ----------------------------------------------------------------------------
// Sequence with all readings measured: a decode step, 22 steps on the
// shared 32x32 multiplier, the run on the serial divider, five final steps
// and one output transfer.
// Skipped readings shorten the run, and the next item is accepted while a
// result waits in the output register.
// Reset (rst, synchronous): coefficients and fine temperature clear to zero.
module sensor_trim_compensation
  import stc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_idx,
  input  wire logic [CfgDataW-1:0] cfg_data,
  stc_if.sink                      in_ch,
  stc_if.source                    out_ch
);
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [2:0]  flags;
  logic [31:0] temp_centi, press_pa;
  logic [16:0] hum_q10;

  stc_ctrl u_ctrl (
    .clk (clk), .rst (rst),
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready),
    .sts (sts), .cmd (cmd), .flags (flags)
  );

  stc_datapath u_dp (
    .clk (clk), .rst (rst),
    .cfg_we (cfg_we), .cfg_idx (cfg_idx), .cfg_data (cfg_data),
    .in_data (in_ch.data[55:0]), .cmd (cmd), .sts (sts),
    .temp_centi (temp_centi), .press_pa (press_pa), .hum_q10 (hum_q10)
  );

  assign out_ch.data = {flags, hum_q10, press_pa, temp_centi};
endmodule
`default_nettype wire

// ----- hdl/stc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_div
// Radix-2 restoring divider, unsigned 32 by 32, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [31:0]      quotient
);
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [5:0]  count;
  logic [32:0] trial;

  assign trial = {rem, quotient[31]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      count    <= 6'd32;
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      // shift in next dividend bit, keep remainder when trial goes negative
      if (trial[32]) begin
        rem <= {rem[30:0], quotient[31]};
      end else begin
        rem <= trial[31:0];
      end
      quotient <= {quotient[30:0], ~trial[32]};
      count    <= count - 6'd1;
      if (count == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/stc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_datapath
// Coefficient registers, working registers, one shared 32x32 multiplier
// and the serial divider of the trim compensation.
// ----------------------------------------------------------------------------
module stc_datapath
  import stc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_idx,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic [55:0]         in_data,
  input  wire dp_cmd_t             cmd,
  output dp_sts_t                  sts,
  output logic [31:0]              temp_centi,
  output logic [31:0]              press_pa,
  output logic [16:0]              hum_q10
);
  logic [47:0] tc;
  logic [63:0] pl;
  logic [63:0] ph;
  logic [47:0] p9h;
  logic [39:0] hh;
  logic [31:0] fine_temp;

  logic [19:0] rt, rp;
  logic [15:0] rh;
  // working registers
  logic [31:0] ra, rb, rc, rd, re;
  logic [31:0] prod;
  logic [31:0] ma, mb;
  logic [31:0] t_res, p_res;
  logic [16:0] h_res;
  logic [31:0] hum_x;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  logic [31:0] div_q;
  logic [31:0] div_n;
  logic        div_busy;
  logic        div_dbl;
  logic [31:0] p_fin;

  assign t1 = {16'd0, tc[15:0]};
  assign t2 = {{16{tc[31]}}, tc[31:16]};
  assign t3 = {{16{tc[47]}}, tc[47:32]};
  assign p1 = {16'd0, pl[15:0]};
  assign p2 = {{16{pl[31]}}, pl[31:16]};
  assign p3 = {{16{pl[47]}}, pl[47:32]};
  assign p4 = {{16{pl[63]}}, pl[63:48]};
  assign p5 = {{16{ph[15]}}, ph[15:0]};
  assign p6 = {{16{ph[31]}}, ph[31:16]};
  assign p7 = {{16{ph[47]}}, ph[47:32]};
  assign p8 = {{16{ph[63]}}, ph[63:48]};
  assign p9 = {{16{p9h[15]}}, p9h[15:0]};
  assign h1 = {24'd0, p9h[23:16]};
  assign h2 = {{16{p9h[39]}}, p9h[39:24]};
  assign h3 = {24'd0, p9h[47:40]};
  assign h4 = {{16{hh[15]}}, hh[15:0]};
  assign h5 = {{16{hh[31]}}, hh[31:16]};
  assign h6 = {{24{hh[39]}}, hh[39:32]};

  // Double the quotient when the dividend could not be shifted up first.
  assign p_fin = div_dbl ? {div_q[30:0], 1'b0} : div_q;
  assign hum_x = rc - asr(prod, 4);

  // Each op multiplies ma*mb (registered in prod by the previous op where
  // needed) then updates working registers with adds and shifts.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_T_A: begin ma = asr({12'd0, rt}, 3) - (t1 << 1); mb = t2; end
      OP_T_B: begin ma = asr({12'd0, rt}, 4) - t1; mb = ma; end
      OP_T_C: begin ma = asr(prod, 12); mb = t3; end
      OP_T_D: begin ma = ra + asr(prod, 14); mb = 32'd5; end
      OP_H_A: begin ma = h5; mb = fine_temp - 32'd76800; end
      OP_H_B: begin ma = fine_temp - 32'd76800; mb = h6; end
      OP_H_C: begin ma = fine_temp - 32'd76800; mb = h3; end
      OP_H_D: begin ma = rb; mb = asr(prod, 11) + 32'd32768; end
      OP_H_E: begin ma = asr(prod, 10) + 32'd2097152; mb = h2; end
      OP_H_F: begin ma = ra; mb = asr(prod + 32'd8192, 14); end
      OP_H_G: begin ma = asr(prod, 15); mb = ma; end
      OP_H_H: begin ma = asr(prod, 7); mb = h1; end
      OP_P_A: begin ma = asr(asr(fine_temp, 1) - 32'd64000, 2); mb = ma; end
      OP_P_B: begin ma = asr(prod, 11); mb = p6; end
      OP_P_C: begin ma = ra; mb = p5; end
      OP_P_D: begin ma = p3; mb = asr(rc, 13); end
      OP_P_E: begin ma = p2; mb = ra; end
      OP_P_F: begin ma = 32'd32768 + asr(asr(rd, 3) + asr(prod, 1), 18); mb = p1; end
      OP_P_G: begin ma = (32'd1048576 - {12'd0, rp}) - asr(rb, 12); mb = 32'd3125; end
      OP_P_I: begin ma = p_fin >> 3; mb = ma; end
      OP_P_J: begin ma = p9; mb = prod >> 13; end
      OP_P_K: begin ma = ra >> 2; mb = p8; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign div_n = prod[31] ? prod : {prod[30:0], 1'b0};

  stc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (rd),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign sts.tv       = (rt != SKIP20);
  assign sts.pv       = (rp != SKIP20);
  assign sts.hv       = (rh != SKIP16);
  assign sts.div_busy = div_busy;
  assign sts.div_zero = (rd == 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      tc        <= '0;
      pl        <= '0;
      ph        <= '0;
      p9h       <= '0;
      hh        <= '0;
      fine_temp <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_TEMP:     tc  <= cfg_data[47:0];
          REG_PRESS_LO: pl  <= cfg_data;
          REG_PRESS_HI: ph  <= cfg_data;
          REG_P9_HUM:   p9h <= cfg_data[47:0];
          REG_HUM_HI:   hh  <= cfg_data[39:0];
          default: ;
        endcase
      end
      if (cmd.step && cmd.op == OP_T_D) begin
        fine_temp <= ma;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rt    <= in_data[19:0];
      rp    <= in_data[39:20];
      rh    <= in_data[55:40];
      t_res <= '0;
      p_res <= '0;
      h_res <= '0;
    end
    if (cmd.div_start) begin
      div_dbl <= prod[31];
    end
    if (cmd.publish) begin
      temp_centi <= t_res;
      press_pa   <= p_res;
      hum_q10    <= h_res;
    end
    if (cmd.step) begin
      prod <= ma * mb;
      case (cmd.op)
        OP_T_A: ;
        OP_T_B: ra <= asr(prod, 11);
        OP_T_E: t_res <= asr(prod + 32'd128, 8);
        OP_H_A: ;
        OP_H_B: ra <= asr((({16'd0, rh} << 14) - (h4 << 20) - prod) + 32'd16384, 15);
        OP_H_C: rb <= asr(prod, 10);
        OP_H_G: rc <= prod;
        OP_H_I: begin
          if (hum_x[31]) begin
            h_res <= '0;
          end else if (hum_x > HUM_CAP) begin
            h_res <= 17'(HUM_CAP >> 12);
          end else begin
            h_res <= 17'(hum_x >> 12);
          end
        end
        OP_P_B: rc <= prod;
        OP_P_C: rb <= prod;
        OP_P_D: rb <= asr(rb + (prod << 1), 2) + (p4 << 16);
        OP_P_E: rd <= prod;
        OP_P_G: rd <= asr(prod, 15);
        OP_P_I: ra <= p_fin;
        OP_P_K: rb <= asr(prod, 12);
        OP_P_L: rc <= asr(prod, 13);
        OP_P_M: p_res <= ra + asr(rb + rc + p7, 4);
        default: ;
      endcase
      if (cmd.op == OP_P_A) begin
        ra <= asr(fine_temp, 1) - 32'd64000;
      end
      if (cmd.op == OP_H_F) begin
        rb <= ra;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/stc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stc_ctrl
// Sequencer: walks the op list of the compensation and runs the divider.
// ----------------------------------------------------------------------------
module stc_ctrl
  import stc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t   cmd,
  output logic [2:0] flags
);
  typedef enum logic [2:0] {S_IDLE, S_RUN, S_DIV, S_DONE} state_t;
  state_t     state;
  op_t        op;
  logic       out_pend;
  logic [2:0] run_flags;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = out_pend;

  always_comb begin
    cmd.load      = in_valid && in_ready;
    cmd.op        = op;
    cmd.step      = (state == S_RUN);
    cmd.div_start = (state == S_RUN) && (op == OP_P_H) && !sts.div_zero;
    // hand over once the output register is free or being emptied
    cmd.publish   = (state == S_DONE) && (!out_pend || out_ready);
  end

  function automatic op_t next_op(input op_t o, input dp_sts_t s);
    next_op = OP_NONE;
    case (o)
      OP_T_E:  next_op = s.hv ? OP_H_A : (s.pv ? OP_P_A : OP_NONE);
      OP_H_I:  next_op = s.pv ? OP_P_A : OP_NONE;
      OP_P_M:  next_op = OP_NONE;
      default: next_op = op_t'(o + 5'd1);
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_NONE;
      flags     <= '0;
      run_flags <= '0;
      out_pend  <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_pend <= 1'b1;
        flags    <= run_flags;
      end else if (out_ready) begin
        out_pend <= 1'b0;
      end
      case (state)
        S_IDLE: if (in_valid) begin
          state <= S_RUN;
          op    <= OP_NONE;
        end
        S_RUN: begin
          if (op == OP_NONE) begin
            run_flags <= {sts.hv, sts.pv, sts.tv};
            op    <= sts.tv ? OP_T_A : (sts.hv ? OP_H_A : (sts.pv ? OP_P_A : OP_NONE));
            if (!sts.tv && !sts.hv && !sts.pv) state <= S_DONE;
          end else if (op == OP_P_H && sts.div_zero) begin
            state <= S_DONE;
          end else if (op == OP_P_H) begin
            state <= S_DIV;
          end else begin
            op <= next_op(op, sts);
            if (next_op(op, sts) == OP_NONE) state <= S_DONE;
          end
        end
        S_DIV: if (!sts.div_busy) begin
          state <= S_RUN;
          op    <= OP_P_I;
        end
        S_DONE: if (cmd.publish) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> $stable(flags))
    else $error("result flags changed while stalled");
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |=> sts.div_busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) (state == S_DIV) |-> !cmd.step)
    else $error("step during divide");
endmodule
`default_nettype wire
